@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BPWU_ASSERT(lbl, expr, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// checked on every edge, reset included
`define BPWU_ASSERT_ALWAYS(lbl, expr, msg) \
lbl: assert property (@(posedge clock) (expr)) else $error(msg);

`endif

@@ rtl/core/bpwu_pkg.sv @@
`timescale 1ns / 1ps

package bpwu_pkg;

   localparam int MAX_LAYERS     = 5;
   localparam int MAX_WIDTH      = 16;
   localparam int VALUE_BITS     = 16;

   localparam int OP_BITS        = 3;
   localparam int LAYER_SEL_BITS = 3;
   localparam int SEL_BITS       = 4;
   localparam int DATA_BITS      = 16;
   localparam int CSR_INDEX_BITS = 4;
   localparam int COUNT_REG_BITS = 3;
   localparam int WIDTH_REG_BITS = 5;
   localparam int GRAD_BITS      = 32;
   localparam int DELTA_BITS     = 34;
   localparam int MUL_A_BITS     = 33;
   localparam int MUL_B_BITS     = 17;
   localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;

   localparam int FRAC_SHIFT     = 12;
   localparam int SCALE_SHIFT    = 14;
   localparam int RATE_SHIFT     = 16;

   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD_WEIGHT = 3'd0,
      OP_LOAD_ACT    = 3'd1,
      OP_LOAD_DER    = 3'd2,
      OP_LOAD_ERR    = 3'd3,
      OP_RUN_UPDATE  = 3'd4,
      OP_READ_WEIGHT = 3'd5
   } op_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEARNING_RATE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WEIGHT_SCALE  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAYER_COUNT   = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH_BASE    = 4'd3;

   localparam logic [DATA_BITS-1:0]      RESET_RATE        = 16'd655;
   localparam logic [DATA_BITS-1:0]      RESET_SCALE       = 16'd16384;
   localparam logic [COUNT_REG_BITS-1:0] RESET_COUNT       = 3'd3;
   localparam logic [WIDTH_REG_BITS-1:0] RESET_WIDTH       = 5'd16;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef logic signed [63:0] wide_type;

   // round half up by s fraction bits
   function automatic wide_type round_sh(input wide_type x, input int unsigned s);
      wide_type half;
      half = 64'sd1 <<< (s - 1);
      return (x + half) >>> s;
   endfunction

   function automatic logic over_bits(input wide_type v, input int unsigned bits);
      wide_type hi;
      wide_type lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) || (v < lo);
   endfunction

   function automatic wide_type clamp_bits(input wide_type v, input int unsigned bits);
      wide_type hi;
      wide_type lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage

@@ rtl/core/bpwu_if.sv @@
`timescale 1ns / 1ps

interface bpwu_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [bpwu_pkg::OP_BITS-1:0]           operation;
   logic [bpwu_pkg::LAYER_SEL_BITS-1:0]    layer_sel;
   logic [bpwu_pkg::SEL_BITS-1:0]          row_sel;
   logic [bpwu_pkg::SEL_BITS-1:0]          col_sel;
   logic signed [bpwu_pkg::DATA_BITS-1:0]  value_in;

   modport source (output valid, operation, layer_sel, row_sel, col_sel, value_in,
                   input ready);
   modport sink   (input valid, operation, layer_sel, row_sel, col_sel, value_in,
                   output ready);
endinterface

interface bpwu_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   result_kind;
   logic signed [bpwu_pkg::DATA_BITS-1:0]  value_out;
   logic                                   saturated;

   modport source (output valid, result_kind, value_out, saturated, input ready);
   modport sink   (input valid, result_kind, value_out, saturated, output ready);
endinterface

interface bpwu_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [bpwu_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [bpwu_pkg::DATA_BITS-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/bpwu_ram.sv @@
`timescale 1ns / 1ps

module bpwu_ram #(
   parameter  int WIDTH     = bpwu_pkg::DATA_BITS,
   parameter  int DEPTH     = bpwu_pkg::MAX_WIDTH,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bpwu_mul.sv @@
`timescale 1ns / 1ps

module bpwu_mul (
   input  logic                                  clock,
   input  logic signed [bpwu_pkg::MUL_A_BITS-1:0] mul_a,
   input  logic signed [bpwu_pkg::MUL_B_BITS-1:0] mul_b,
   output logic signed [bpwu_pkg::PROD_BITS-1:0]  product
);

   logic signed [bpwu_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [bpwu_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = bpwu_pkg::PROD_BITS'(mul_a) * bpwu_pkg::PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

@@ rtl/core/mlp_backprop_weight_update.sv @@
`timescale 1ns / 1ps
// loads are written on acceptance; a weight read passes ST_RD_WAIT, then its beat is registered
// a run forms the top output gradient, then updates each layer from the top down,
// first passing a gradient down for every layer above layer 1
// every product goes through one registered 33x17 multiplier under the sequencer
// reset is synchronous: control and config registers return to defaults,
// the weight, vector and gradient memories stay undefined until written

`include "assert_macros.svh"

module mlp_backprop_weight_update #(
   parameter int MAX_LAYERS = bpwu_pkg::MAX_LAYERS,
   parameter int MAX_WIDTH  = bpwu_pkg::MAX_WIDTH
) (
   input logic        clock,
   input logic        reset,
   bpwu_req_if.sink   req_if,
   bpwu_rsp_if.source rsp_if,
   bpwu_csr_if.sink   csr_if
);

   localparam int WIDX     = $clog2(MAX_WIDTH);
   localparam int CNTB     = $clog2(MAX_WIDTH + 1);
   localparam int LB       = $clog2(MAX_LAYERS);
   localparam int VEC_DEP  = MAX_LAYERS * MAX_WIDTH;
   localparam int VEC_AW   = $clog2(VEC_DEP);
   localparam int W_DEP    = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
   localparam int W_AW     = $clog2(W_DEP);
   localparam int G_DEP    = 2 * MAX_WIDTH;
   localparam int G_AW     = WIDX + 1;
   localparam int DB       = bpwu_pkg::DATA_BITS;
   localparam int GB       = bpwu_pkg::GRAD_BITS;
   localparam int ACC_BITS = 48 + WIDX;

   typedef enum logic [18:0] {
      ST_IDLE    = 19'h00001,
      ST_RD_WAIT = 19'h00002,
      ST_OG_RD   = 19'h00004,
      ST_OG_MUL  = 19'h00008,
      ST_OG_WR   = 19'h00010,
      ST_LAYER   = 19'h00020,
      ST_HG_RD   = 19'h00040,
      ST_HG_MUL  = 19'h00080,
      ST_HG_ACC  = 19'h00100,
      ST_HG_RND  = 19'h00200,
      ST_HG_DMUL = 19'h00400,
      ST_HG_DWR  = 19'h00800,
      ST_UP_RD   = 19'h01000,
      ST_UP_GA   = 19'h02000,
      ST_UP_DEL  = 19'h04000,
      ST_UP_DMUL = 19'h08000,
      ST_UP_KMUL = 19'h10000,
      ST_UP_WR   = 19'h20000,
      ST_DONE    = 19'h40000
   } state_type;

   function automatic logic [CNTB-1:0] eff_width(input logic [bpwu_pkg::WIDTH_REG_BITS-1:0] w);
      if (int'(w) < 1) begin
         return CNTB'(1);
      end else if (int'(w) > MAX_WIDTH) begin
         return CNTB'(MAX_WIDTH);
      end
      return CNTB'(w);
   endfunction

   function automatic logic [W_AW-1:0] w_addr(input logic [LB-1:0] l, input logic [WIDX-1:0] r,
                                              input logic [WIDX-1:0] c);
      return W_AW'((int'(l) * MAX_WIDTH + int'(r)) * MAX_WIDTH + int'(c));
   endfunction

   function automatic logic [VEC_AW-1:0] v_addr(input logic [LB-1:0] l,
                                                input logic [WIDX-1:0] n);
      return VEC_AW'(int'(l) * MAX_WIDTH + int'(n));
   endfunction

   // config registers
   logic [DB-1:0]                           rate_ff;
   logic [DB-1:0]                           scale_ff;
   logic [bpwu_pkg::COUNT_REG_BITS-1:0]     lcount_ff;
   logic [bpwu_pkg::WIDTH_REG_BITS-1:0]     lwidth_ff [MAX_LAYERS];
   logic [LB-1:0]                           csr_wsel;
   logic                                    csr_wsel_ok;

   assign csr_if.ready = 1'b1;
   assign csr_wsel_ok  = (int'(csr_if.index) >= int'(bpwu_pkg::CSR_WIDTH_BASE)) &&
                         (int'(csr_if.index) - int'(bpwu_pkg::CSR_WIDTH_BASE) < MAX_LAYERS);
   assign csr_wsel     = LB'(int'(csr_if.index) - int'(bpwu_pkg::CSR_WIDTH_BASE));

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= bpwu_pkg::RESET_RATE;
         scale_ff  <= bpwu_pkg::RESET_SCALE;
         lcount_ff <= bpwu_pkg::RESET_COUNT;
         for (int n = 0; n < MAX_LAYERS; n++) begin
            lwidth_ff[n] <= bpwu_pkg::RESET_WIDTH;
         end
      end else if (csr_if.valid) begin
         if (csr_if.index == bpwu_pkg::CSR_LEARNING_RATE) begin
            rate_ff <= csr_if.data;
         end else if (csr_if.index == bpwu_pkg::CSR_WEIGHT_SCALE) begin
            scale_ff <= csr_if.data;
         end else if (csr_if.index == bpwu_pkg::CSR_LAYER_COUNT) begin
            lcount_ff <= csr_if.data[bpwu_pkg::COUNT_REG_BITS-1:0];
         end else if (csr_wsel_ok) begin
            lwidth_ff[csr_wsel] <= csr_if.data[bpwu_pkg::WIDTH_REG_BITS-1:0];
         end
      end
   end

   // top layer index from the clamped layer count
   logic [LB-1:0] top_layer;
   always_comb begin
      if (int'(lcount_ff) < 2) begin
         top_layer = LB'(1);
      end else if (int'(lcount_ff) > MAX_LAYERS) begin
         top_layer = LB'(MAX_LAYERS - 1);
      end else begin
         top_layer = LB'(int'(lcount_ff) - 1);
      end
   end

   // sequencer state
   state_type                    state_ff, state_in;
   logic [LB-1:0]                i_ff, i_in;
   logic [WIDX-1:0]              j_ff, j_in;
   logic [WIDX-1:0]              k_ff, k_in;
   logic [WIDX-1:0]              r_ff, r_in;
   logic [WIDX-1:0]              c_ff, c_in;
   logic [CNTB-1:0]              rows_ff, rows_in;
   logic [CNTB-1:0]              cols_ff, cols_in;
   logic                         cur_ff, cur_in;
   logic                         clip_ff, clip_in;
   logic                         rd_ok_ff, rd_ok_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic signed [DB-1:0]         rsp_value_ff, rsp_value_in;
   logic                         rsp_sat_ff, rsp_sat_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic signed [GB-1:0]         t_ff, t_in;
   logic signed [bpwu_pkg::DELTA_BITS-1:0] d_ff, d_in;

   logic [LB-1:0]                im1;
   assign im1 = i_ff - LB'(1);

   // memories
   logic              w_we, w_re;
   logic [W_AW-1:0]   w_waddr, w_raddr;
   logic [DB-1:0]     w_wdata, w_rdata;
   logic              a_we, a_re;
   logic [VEC_AW-1:0] a_waddr, a_raddr;
   logic [DB-1:0]     a_rdata;
   logic              dr_we, dr_re;
   logic [VEC_AW-1:0] dr_waddr, dr_raddr;
   logic [DB-1:0]     dr_rdata;
   logic              e_we, e_re;
   logic [WIDX-1:0]   e_waddr, e_raddr;
   logic [DB-1:0]     e_rdata;
   logic              g_we, g_re;
   logic [G_AW-1:0]   g_waddr, g_raddr;
   logic [GB-1:0]     g_wdata, g_rdata;

   bpwu_ram #(.WIDTH(DB), .DEPTH(W_DEP)) u_weight_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
      .rd_en(w_re), .rd_addr(w_raddr), .rd_data(w_rdata));

   bpwu_ram #(.WIDTH(DB), .DEPTH(VEC_DEP)) u_act_ram (
      .clock(clock), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(req_if.value_in),
      .rd_en(a_re), .rd_addr(a_raddr), .rd_data(a_rdata));

   bpwu_ram #(.WIDTH(DB), .DEPTH(VEC_DEP)) u_der_ram (
      .clock(clock), .wr_en(dr_we), .wr_addr(dr_waddr), .wr_data(req_if.value_in),
      .rd_en(dr_re), .rd_addr(dr_raddr), .rd_data(dr_rdata));

   bpwu_ram #(.WIDTH(DB), .DEPTH(MAX_WIDTH)) u_err_ram (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(req_if.value_in),
      .rd_en(e_re), .rd_addr(e_raddr), .rd_data(e_rdata));

   bpwu_ram #(.WIDTH(GB), .DEPTH(G_DEP)) u_grad_ram (
      .clock(clock), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
      .rd_en(g_re), .rd_addr(g_raddr), .rd_data(g_rdata));

   // shared multiplier
   logic signed [bpwu_pkg::MUL_A_BITS-1:0] mul_a;
   logic signed [bpwu_pkg::MUL_B_BITS-1:0] mul_b;
   logic signed [bpwu_pkg::PROD_BITS-1:0]  product;

   bpwu_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .product(product));

   // rounding and saturation of the registered product and the accumulator
   bpwu_pkg::wide_type prod_w, r12, acc_r, kept, delta, diff;
   assign prod_w = bpwu_pkg::wide_type'(product);
   assign r12    = bpwu_pkg::round_sh(prod_w, bpwu_pkg::FRAC_SHIFT);
   assign acc_r  = bpwu_pkg::round_sh(bpwu_pkg::wide_type'(acc_ff), bpwu_pkg::FRAC_SHIFT);
   assign kept   = bpwu_pkg::round_sh(prod_w, bpwu_pkg::SCALE_SHIFT);
   assign delta  = bpwu_pkg::round_sh(prod_w, bpwu_pkg::RATE_SHIFT);
   assign diff   = kept - bpwu_pkg::wide_type'(d_ff);

   logic signed [GB-1:0] r12_sat, acc_sat;
   logic signed [DB-1:0] new_w;
   assign r12_sat = GB'(bpwu_pkg::clamp_bits(r12, GB));
   assign acc_sat = GB'(bpwu_pkg::clamp_bits(acc_r, GB));
   assign new_w   = DB'(bpwu_pkg::clamp_bits(diff, bpwu_pkg::VALUE_BITS));

   // request decode
   logic            req_fire, req_wok, req_vok, req_cok;
   logic [LB-1:0]   req_lay;
   logic [WIDX-1:0] req_row, req_col;

   assign req_if.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_cok      = int'(req_if.col_sel) < MAX_WIDTH;
   assign req_wok      = (int'(req_if.layer_sel) < MAX_LAYERS - 1) &&
                         (int'(req_if.row_sel) < MAX_WIDTH) && req_cok;
   assign req_vok      = (int'(req_if.layer_sel) < MAX_LAYERS) && req_cok;
   assign req_lay      = LB'(int'(req_if.layer_sel));
   assign req_row      = WIDX'(int'(req_if.row_sel));
   assign req_col      = WIDX'(int'(req_if.col_sel));

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      cur_in       = cur_ff;
      clip_in      = clip_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      d_in         = d_ff;
      w_we = 1'b0; w_re = 1'b0; w_waddr = '0; w_raddr = '0; w_wdata = '0;
      a_we = 1'b0; a_re = 1'b0; a_waddr = '0; a_raddr = '0;
      dr_we = 1'b0; dr_re = 1'b0; dr_waddr = '0; dr_raddr = '0;
      e_we = 1'b0; e_re = 1'b0; e_waddr = '0; e_raddr = '0;
      g_we = 1'b0; g_re = 1'b0; g_waddr = '0; g_raddr = '0; g_wdata = '0;
      mul_a = '0;
      mul_b = '0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.operation)
                  bpwu_pkg::OP_LOAD_WEIGHT: begin
                     w_we    = req_wok;
                     w_waddr = w_addr(req_lay, req_row, req_col);
                     w_wdata = req_if.value_in;
                  end
                  bpwu_pkg::OP_LOAD_ACT: begin
                     a_we    = req_vok;
                     a_waddr = v_addr(req_lay, req_col);
                  end
                  bpwu_pkg::OP_LOAD_DER: begin
                     dr_we    = req_vok;
                     dr_waddr = v_addr(req_lay, req_col);
                  end
                  bpwu_pkg::OP_LOAD_ERR: begin
                     e_we    = req_cok;
                     e_waddr = req_col;
                  end
                  bpwu_pkg::OP_RUN_UPDATE: begin
                     clip_in  = 1'b0;
                     cur_in   = 1'b0;
                     j_in     = '0;
                     i_in     = top_layer;
                     cols_in  = eff_width(lwidth_ff[top_layer]);
                     state_in = ST_OG_RD;
                  end
                  bpwu_pkg::OP_READ_WEIGHT: begin
                     w_re     = 1'b1;
                     w_raddr  = w_addr(req_lay, req_row, req_col);
                     rd_ok_in = req_wok;
                     state_in = ST_RD_WAIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = bpwu_pkg::KIND_READ;
            rsp_value_in = rd_ok_ff ? w_rdata : '0;
            rsp_sat_in   = clip_ff;
            state_in     = ST_IDLE;
         end
         ST_OG_RD: begin
            e_re     = 1'b1;
            e_raddr  = j_ff;
            dr_re    = 1'b1;
            dr_raddr = v_addr(i_ff, j_ff);
            state_in = ST_OG_MUL;
         end
         ST_OG_MUL: begin
            mul_a    = bpwu_pkg::MUL_A_BITS'($signed(e_rdata));
            mul_b    = bpwu_pkg::MUL_B_BITS'($signed(dr_rdata));
            state_in = ST_OG_WR;
         end
         ST_OG_WR: begin
            g_we    = 1'b1;
            g_waddr = {cur_ff, j_ff};
            g_wdata = r12_sat;
            clip_in = clip_ff | bpwu_pkg::over_bits(r12, GB);
            if (CNTB'(j_ff) + CNTB'(1) == cols_ff) begin
               state_in = ST_LAYER;
            end else begin
               j_in     = j_ff + WIDX'(1);
               state_in = ST_OG_RD;
            end
         end
         ST_LAYER: begin
            rows_in = eff_width(lwidth_ff[im1]);
            cols_in = eff_width(lwidth_ff[i_ff]);
            j_in    = '0;
            k_in    = '0;
            r_in    = '0;
            c_in    = '0;
            acc_in  = '0;
            state_in = (int'(i_ff) >= 2) ? ST_HG_RD : ST_UP_RD;
         end
         ST_HG_RD: begin
            g_re     = 1'b1;
            g_raddr  = {cur_ff, j_ff};
            w_re     = 1'b1;
            w_raddr  = w_addr(im1, k_ff, j_ff);
            state_in = ST_HG_MUL;
         end
         ST_HG_MUL: begin
            mul_a    = bpwu_pkg::MUL_A_BITS'($signed(g_rdata));
            mul_b    = bpwu_pkg::MUL_B_BITS'($signed(w_rdata));
            state_in = ST_HG_ACC;
         end
         ST_HG_ACC: begin
            acc_in = acc_ff + ACC_BITS'(product);
            if (CNTB'(j_ff) + CNTB'(1) == cols_ff) begin
               j_in     = '0;
               state_in = ST_HG_RND;
            end else begin
               j_in     = j_ff + WIDX'(1);
               state_in = ST_HG_RD;
            end
         end
         ST_HG_RND: begin
            t_in     = acc_sat;
            clip_in  = clip_ff | bpwu_pkg::over_bits(acc_r, GB);
            dr_re    = 1'b1;
            dr_raddr = v_addr(im1, k_ff);
            state_in = ST_HG_DMUL;
         end
         ST_HG_DMUL: begin
            mul_a    = bpwu_pkg::MUL_A_BITS'(t_ff);
            mul_b    = bpwu_pkg::MUL_B_BITS'($signed(dr_rdata));
            state_in = ST_HG_DWR;
         end
         ST_HG_DWR: begin
            g_we    = 1'b1;
            g_waddr = {~cur_ff, k_ff};
            g_wdata = r12_sat;
            clip_in = clip_ff | bpwu_pkg::over_bits(r12, GB);
            acc_in  = '0;
            if (CNTB'(k_ff) + CNTB'(1) == rows_ff) begin
               state_in = ST_UP_RD;
            end else begin
               k_in     = k_ff + WIDX'(1);
               state_in = ST_HG_RD;
            end
         end
         ST_UP_RD: begin
            g_re     = 1'b1;
            g_raddr  = {cur_ff, c_ff};
            a_re     = 1'b1;
            a_raddr  = v_addr(im1, r_ff);
            w_re     = 1'b1;
            w_raddr  = w_addr(im1, r_ff, c_ff);
            state_in = ST_UP_GA;
         end
         ST_UP_GA: begin
            mul_a    = bpwu_pkg::MUL_A_BITS'($signed(g_rdata));
            mul_b    = bpwu_pkg::MUL_B_BITS'($signed(a_rdata));
            state_in = ST_UP_DEL;
         end
         ST_UP_DEL: begin
            t_in     = r12_sat;
            clip_in  = clip_ff | bpwu_pkg::over_bits(r12, GB);
            state_in = ST_UP_DMUL;
         end
         ST_UP_DMUL: begin
            mul_a    = bpwu_pkg::MUL_A_BITS'(t_ff);
            mul_b    = $signed({1'b0, rate_ff});
            state_in = ST_UP_KMUL;
         end
         ST_UP_KMUL: begin
            d_in     = bpwu_pkg::DELTA_BITS'(delta);
            mul_a    = bpwu_pkg::MUL_A_BITS'($signed(w_rdata));
            mul_b    = $signed({1'b0, scale_ff});
            state_in = ST_UP_WR;
         end
         ST_UP_WR: begin
            w_we    = 1'b1;
            w_waddr = w_addr(im1, r_ff, c_ff);
            w_wdata = new_w;
            clip_in = clip_ff | bpwu_pkg::over_bits(diff, bpwu_pkg::VALUE_BITS);
            if (CNTB'(c_ff) + CNTB'(1) == cols_ff) begin
               c_in = '0;
               if (CNTB'(r_ff) + CNTB'(1) == rows_ff) begin
                  cur_in = ~cur_ff;
                  if (int'(i_ff) == 1) begin
                     state_in = ST_DONE;
                  end else begin
                     i_in     = im1;
                     state_in = ST_LAYER;
                  end
               end else begin
                  r_in     = r_ff + WIDX'(1);
                  state_in = ST_UP_RD;
               end
            end else begin
               c_in     = c_ff + WIDX'(1);
               state_in = ST_UP_RD;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = bpwu_pkg::KIND_DONE;
            rsp_value_in = '0;
            rsp_sat_in   = clip_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         rows_ff      <= '0;
         cols_ff      <= '0;
         cur_ff       <= 1'b0;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         cur_ff       <= cur_in;
         rd_ok_ff     <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      acc_ff       <= acc_in;
      t_ff         <= t_in;
      d_ff         <= d_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = rsp_kind_ff;
   assign rsp_if.value_out   = rsp_value_ff;
   assign rsp_if.saturated   = rsp_sat_ff;

   `BPWU_ASSERT(a_run_clears_clip, (req_fire && (req_if.operation == bpwu_pkg::OP_RUN_UPDATE)) |=> !clip_ff, "clip flag not cleared at run start")
   `BPWU_ASSERT(a_done_after_update, (state_ff == ST_DONE) |-> $past(state_ff == ST_UP_WR), "run finished without a weight write")
   `BPWU_ASSERT(a_done_beat_zero, (rsp_valid_ff && (rsp_kind_ff == bpwu_pkg::KIND_DONE)) |-> (rsp_value_ff == '0), "update beat carries data")
   `BPWU_ASSERT(a_update_in_range, (state_ff == ST_UP_RD) |-> ((CNTB'(c_ff) < cols_ff) && (CNTB'(r_ff) < rows_ff)), "weight index beyond layer size")
   `BPWU_ASSERT_ALWAYS(a_busy_no_beat, (state_ff != ST_IDLE && state_ff != ST_RD_WAIT && state_ff != ST_DONE) |-> !rsp_valid_ff, "result pending during a run")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam logic [bpwu_pkg::OP_BITS-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [bpwu_pkg::OP_BITS-1:0] OP_SPARE_HI = 3'd7;
   localparam int MAX_LAYERS = bpwu_pkg::MAX_LAYERS;
   localparam int MAX_WIDTH  = bpwu_pkg::MAX_WIDTH;
   localparam int NMAT       = MAX_LAYERS - 1;

   typedef struct {
      logic               kind;
      logic signed [15:0] value;
      logic               sat;
   } beat_type;

   typedef struct {
      bit       typed;
      beat_type b;
   } tag_type;

   typedef struct {
      logic [2:0]  op;
      logic [2:0]  lay;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [15:0] val;
      bit          typed;
      logic        kind;
      logic [15:0] value;
      logic        sat;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   bpwu_req_if req();
   bpwu_rsp_if rsp();
   bpwu_csr_if csr();

   mlp_backprop_weight_update dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   // model state
   logic [15:0]        rate_reg;
   logic [15:0]        scale_reg;
   logic [2:0]         count_reg;
   logic [4:0]         width_reg [MAX_LAYERS];
   logic signed [15:0] wmem [NMAT][MAX_WIDTH][MAX_WIDTH];
   logic signed [15:0] amem [MAX_LAYERS][MAX_WIDTH];
   logic signed [15:0] dmem [MAX_LAYERS][MAX_WIDTH];
   logic signed [15:0] emem [MAX_WIDTH];
   logic signed [31:0] grad [2][MAX_WIDTH];
   bit                 clipped;

   beat_type expected_q [$];
   tag_type  tag_mem [int];
   int       n_sent;
   int       n_taken;
   int       errors;
   int       cyc;
   bit       calm;
   bit       hold_req;
   bit       hold_done;
   int       hold_left;
   int       nitems;

   // entries written so far, as seen by the stimulus
   bit w_ok [NMAT][MAX_WIDTH][MAX_WIDTH];
   bit a_ok [MAX_LAYERS][MAX_WIDTH];
   bit d_ok [MAX_LAYERS][MAX_WIDTH];
   bit e_ok [MAX_WIDTH];

   function automatic longint rnd(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sat_to(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         clipped = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clipped = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic int layers_eff();
      int n;
      n = count_reg;
      if (n < 2) n = 2;
      if (n > MAX_LAYERS) n = MAX_LAYERS;
      return n;
   endfunction

   function automatic int width_eff(int k);
      int w;
      w = width_reg[k];
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic void update_weights();
      int top;
      int cur;
      int nxt;
      int rows;
      int cols;
      longint acc;
      longint ga;
      longint delta;
      longint kept;
      clipped = 1'b0;
      top = layers_eff() - 1;
      cur = 0;
      for (int j = 0; j < width_eff(top); j++) begin
         grad[cur][j] = 32'(sat_to(rnd(longint'(emem[j]) * longint'(dmem[top][j]), 12), 32));
      end
      for (int i = top; i >= 1; i--) begin
         rows = width_eff(i - 1);
         cols = width_eff(i);
         nxt = cur ^ 1;
         if (i >= 2) begin
            for (int k = 0; k < rows; k++) begin
               acc = 0;
               for (int j = 0; j < cols; j++) begin
                  acc += longint'(grad[cur][j]) * longint'(wmem[i-1][k][j]);
                  if (acc > (64'sd1 <<< 62)) acc = 64'sd1 <<< 62;
                  if (acc < -(64'sd1 <<< 62)) acc = -(64'sd1 <<< 62);
               end
               acc = sat_to(rnd(acc, 12), 32);
               acc = sat_to(rnd(acc * longint'(dmem[i-1][k]), 12), 32);
               grad[nxt][k] = 32'(acc);
            end
         end
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               ga = sat_to(rnd(longint'(grad[cur][c]) * longint'(amem[i-1][r]), 12), 32);
               delta = rnd(ga * longint'(rate_reg), 16);
               kept = rnd(longint'(wmem[i-1][r][c]) * longint'(scale_reg), 14);
               wmem[i-1][r][c] = 16'(sat_to(kept - delta, bpwu_pkg::VALUE_BITS));
            end
         end
         cur = nxt;
      end
   endfunction

   function automatic bit model_item(logic [2:0] op, logic [2:0] lay, logic [3:0] row,
                                     logic [3:0] col, logic signed [15:0] val,
                                     output beat_type b);
      bit wok;
      bit vok;
      wok = lay < NMAT;
      vok = lay < MAX_LAYERS;
      b.kind = bpwu_pkg::KIND_DONE;
      b.value = '0;
      b.sat = 1'b0;
      case (op)
         bpwu_pkg::OP_LOAD_WEIGHT: begin
            if (wok) wmem[lay][row][col] = val;
            return 1'b0;
         end
         bpwu_pkg::OP_LOAD_ACT: begin
            if (vok) amem[lay][col] = val;
            return 1'b0;
         end
         bpwu_pkg::OP_LOAD_DER: begin
            if (vok) dmem[lay][col] = val;
            return 1'b0;
         end
         bpwu_pkg::OP_LOAD_ERR: begin
            emem[col] = val;
            return 1'b0;
         end
         bpwu_pkg::OP_RUN_UPDATE: begin
            update_weights();
            b.sat = clipped;
            return 1'b1;
         end
         bpwu_pkg::OP_READ_WEIGHT: begin
            b.kind = bpwu_pkg::KIND_READ;
            b.value = wok ? wmem[lay][row][col] : 16'sd0;
            b.sat = clipped;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      beat_type pb;
      beat_type e;
      tag_type  t;
      if (reset) begin
         rate_reg = bpwu_pkg::RESET_RATE;
         scale_reg = bpwu_pkg::RESET_SCALE;
         count_reg = bpwu_pkg::RESET_COUNT;
         for (int k = 0; k < MAX_LAYERS; k++) width_reg[k] = bpwu_pkg::RESET_WIDTH;
         clipped = 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == bpwu_pkg::CSR_LEARNING_RATE) rate_reg = csr.data;
            else if (csr.index == bpwu_pkg::CSR_WEIGHT_SCALE) scale_reg = csr.data;
            else if (csr.index == bpwu_pkg::CSR_LAYER_COUNT) count_reg = csr.data[2:0];
            else if (csr.index >= bpwu_pkg::CSR_WIDTH_BASE &&
                     csr.index < bpwu_pkg::CSR_WIDTH_BASE + MAX_LAYERS)
               width_reg[csr.index - bpwu_pkg::CSR_WIDTH_BASE] = csr.data[4:0];
         end
         if (req.valid && req.ready) begin
            t = tag_mem[n_taken];
            n_taken++;
            if (model_item(req.operation, req.layer_sel, req.row_sel, req.col_sel,
                           req.value_in, pb)) begin
               if (t.typed) expected_q.insert(expected_q.size(), t.b);
               else expected_q.insert(expected_q.size(), pb);
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: beat with nothing expected: kind %0d value %0d sat %0d",
                        $time, rsp.result_kind, rsp.value_out, rsp.saturated);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp.result_kind !== e.kind || rsp.value_out !== e.value ||
                   rsp.saturated !== e.sat) begin
                  $display("%0t: expected kind %0d value %0d sat %0d, got %0d %0d %0d",
                           $time, e.kind, e.value, e.sat,
                           rsp.result_kind, rsp.value_out, rsp.saturated);
                  errors++;
               end
            end
         end
      end
   end

   // result side: random stalls, a calm stretch and one long hold-off
   always @(posedge clock) begin : stall
      cyc++;
      calm = cyc >= 3000 && cyc < 6000;
      if (hold_req && !hold_done) begin
         hold_left = 500;
         hold_done = 1'b1;
      end
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= calm || $urandom_range(99) >= 36;
      end
   end

   function automatic logic [2:0] any3();
      return 3'($urandom);
   endfunction

   function automatic logic [3:0] any4();
      return 4'($urandom);
   endfunction

   function automatic logic [15:0] any16();
      return 16'($urandom);
   endfunction

   task automatic send(logic [2:0] op, logic [2:0] lay, logic [3:0] row, logic [3:0] col,
                       logic [15:0] val, bit typed = 0, logic kind = bpwu_pkg::KIND_DONE,
                       logic [15:0] value = 16'h0000, logic sat = 1'b0);
      tag_type t;
      t.typed = typed;
      t.b.kind = kind;
      t.b.value = value;
      t.b.sat = sat;
      tag_mem[n_sent] = t;
      n_sent++;
      while (!calm && $urandom_range(99) < 36) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.operation <= op;
      req.layer_sel <= lay;
      req.row_sel <= row;
      req.col_sel <= col;
      req.value_in <= val;
      do @(posedge clock); while (!req.ready);
      case (op)
         bpwu_pkg::OP_LOAD_WEIGHT: if (lay < NMAT) w_ok[lay][row][col] = 1'b1;
         bpwu_pkg::OP_LOAD_ACT: if (lay < MAX_LAYERS) a_ok[lay][col] = 1'b1;
         bpwu_pkg::OP_LOAD_DER: if (lay < MAX_LAYERS) d_ok[lay][col] = 1'b1;
         bpwu_pkg::OP_LOAD_ERR: e_ok[col] = 1'b1;
         default: ;
      endcase
   endtask

   task automatic csr_write(logic [3:0] idx, logic [15:0] data);
      while (!calm && $urandom_range(99) < 36) begin
         csr.valid <= 1'b0;
         @(posedge clock);
      end
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= data;
      do @(posedge clock); while (!csr.ready);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      csr.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_val();
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom);
         3, 4: return 16'($signed($urandom_range(16384)) - 8192);
         default: return $urandom_range(1) ? 16'h1000 : 16'h0000;
      endcase
   endfunction

   function automatic logic [15:0] pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 7) return 16'd16;
      if (r < 12) return $urandom_range(1) ? 16'd0 : 16'($urandom_range(31, 17));
      return 16'($urandom_range(4, 1));
   endfunction

   task automatic configure();
      logic [15:0] v;
      case ($urandom_range(3))
         0: v = 16'd0;
         1: v = 16'hffff;
         default: v = 16'($urandom);
      endcase
      csr_write(bpwu_pkg::CSR_LEARNING_RATE, v);
      case ($urandom_range(4))
         0: v = 16'd0;
         1: v = 16'hffff;
         2: v = 16'd16384;
         default: v = 16'($urandom);
      endcase
      csr_write(bpwu_pkg::CSR_WEIGHT_SCALE, v);
      if ($urandom_range(9) == 0) begin
         v = 16'($urandom_range(1) ? $urandom_range(1) : 6 + $urandom_range(1));
      end else begin
         v = 16'($urandom_range(5, 2));
      end
      csr_write(bpwu_pkg::CSR_LAYER_COUNT, {13'($urandom_range(8191)), v[2:0]});
      for (int k = 0; k < MAX_LAYERS; k++) begin
         v = pick_width();
         csr_write(4'(bpwu_pkg::CSR_WIDTH_BASE + k), {11'($urandom), v[4:0]});
      end
      drain();
   endtask

   task automatic read_written();
      logic [2:0] l;
      logic [3:0] r;
      logic [3:0] c;
      for (int n = 0; n < 30; n++) begin
         l = 3'($urandom_range(NMAT - 1));
         r = any4();
         c = any4();
         if (w_ok[l][r][c]) begin
            send(bpwu_pkg::OP_READ_WEIGHT, l, r, c, any16());
            nitems++;
            return;
         end
      end
   endtask

   task automatic noise();
      case ($urandom_range(5))
         0: send(bpwu_pkg::OP_LOAD_WEIGHT, 3'($urandom_range(7, NMAT)), any4(), any4(), any16());
         1: send($urandom_range(1) ? bpwu_pkg::OP_LOAD_ACT : bpwu_pkg::OP_LOAD_DER,
                 3'($urandom_range(7, MAX_LAYERS)), any4(), any4(), any16());
         2: send($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI,
                 any3(), any4(), any4(), any16());
         3: begin
            send(bpwu_pkg::OP_READ_WEIGHT, 3'($urandom_range(7, NMAT)), any4(), any4(),
                 any16());
            nitems++;
         end
         default: read_written();
      endcase
   endtask

   task automatic fill_and_run();
      script_row_type loads [$];
      script_row_type s;
      script_row_type tmp;
      int top;
      int j;
      top = layers_eff() - 1;
      s.typed = 0;
      s.kind = bpwu_pkg::KIND_DONE;
      s.value = 16'h0000;
      s.sat = 1'b0;
      for (int n = 0; n < width_eff(top); n++) begin
         if (!e_ok[n] || $urandom_range(1)) begin
            s.op = bpwu_pkg::OP_LOAD_ERR; s.lay = any3(); s.row = any4(); s.col = 4'(n);
            s.val = pick_val();
            loads.insert(loads.size(), s);
         end
         if (!d_ok[top][n] || $urandom_range(1)) begin
            s.op = bpwu_pkg::OP_LOAD_DER; s.lay = 3'(top); s.row = any4(); s.col = 4'(n);
            s.val = pick_val();
            loads.insert(loads.size(), s);
         end
      end
      for (int i = top; i >= 1; i--) begin
         for (int r = 0; r < width_eff(i - 1); r++) begin
            if (!a_ok[i-1][r] || $urandom_range(1)) begin
               s.op = bpwu_pkg::OP_LOAD_ACT; s.lay = 3'(i - 1); s.row = any4();
               s.col = 4'(r); s.val = pick_val();
               loads.insert(loads.size(), s);
            end
            if (i >= 2 && (!d_ok[i-1][r] || $urandom_range(1))) begin
               s.op = bpwu_pkg::OP_LOAD_DER; s.lay = 3'(i - 1); s.row = any4();
               s.col = 4'(r); s.val = pick_val();
               loads.insert(loads.size(), s);
            end
            for (int c = 0; c < width_eff(i); c++) begin
               if (!w_ok[i-1][r][c] || $urandom_range(1)) begin
                  s.op = bpwu_pkg::OP_LOAD_WEIGHT; s.lay = 3'(i - 1); s.row = 4'(r);
                  s.col = 4'(c); s.val = pick_val();
                  loads.insert(loads.size(), s);
               end
            end
         end
      end
      for (int n = loads.size() - 1; n > 0; n--) begin
         j = int'($urandom_range(n));
         tmp = loads[n];
         loads[n] = loads[j];
         loads[j] = tmp;
      end
      foreach (loads[n]) begin
         if ($urandom_range(99) < 12) noise();
         send(loads[n].op, loads[n].lay, loads[n].row, loads[n].col, loads[n].val);
         nitems++;
      end
      send(bpwu_pkg::OP_RUN_UPDATE, any3(), any4(), any4(), any16());
      nitems++;
      repeat ($urandom_range(6)) read_written();
      if ($urandom_range(99) < 30) begin
         send(bpwu_pkg::OP_RUN_UPDATE, any3(), any4(), any4(), any16());
         nitems++;
         repeat ($urandom_range(3)) read_written();
      end
   endtask

   script_row_type script [] = '{
      '{bpwu_pkg::OP_READ_WEIGHT, 3'd4, 4'd0, 4'd0, 16'h0000, 1, bpwu_pkg::KIND_READ,
        16'h0000, 1'b0},
      '{bpwu_pkg::OP_READ_WEIGHT, 3'd7, 4'd15, 4'd15, 16'hffff, 1, bpwu_pkg::KIND_READ,
        16'h0000, 1'b0},
      '{bpwu_pkg::OP_LOAD_WEIGHT, 3'd0, 4'd0, 4'd0, 16'h7fff, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_READ_WEIGHT, 3'd0, 4'd0, 4'd0, 16'h0000, 1, bpwu_pkg::KIND_READ,
        16'h7fff, 1'b0},
      '{bpwu_pkg::OP_LOAD_WEIGHT, 3'd3, 4'd15, 4'd15, 16'h8000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_READ_WEIGHT, 3'd3, 4'd15, 4'd15, 16'h0000, 1, bpwu_pkg::KIND_READ,
        16'h8000, 1'b0},
      '{bpwu_pkg::OP_LOAD_WEIGHT, 3'd4, 4'd0, 4'd0, 16'h0005, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_READ_WEIGHT, 3'd4, 4'd0, 4'd0, 16'h0000, 1, bpwu_pkg::KIND_READ,
        16'h0000, 1'b0},
      '{bpwu_pkg::OP_LOAD_ACT, 3'd7, 4'd0, 4'd0, 16'h1234, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_DER, 3'd5, 4'd0, 4'd0, 16'h1234, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{OP_SPARE_LO, 3'd0, 4'd0, 4'd0, 16'h0000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{OP_SPARE_HI, 3'd7, 4'd15, 4'd15, 16'hffff, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_ACT, 3'd0, 4'd9, 4'd0, 16'h1000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_DER, 3'd1, 4'd3, 4'd0, 16'h8000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_ERR, 3'd6, 4'd15, 4'd0, 16'h7fff, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_ERR, 3'd2, 4'd1, 4'd15, 16'hffff, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_ACT, 3'd4, 4'd0, 4'd15, 16'h0001, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_RUN_UPDATE, 3'd0, 4'd0, 4'd0, 16'h0000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_READ_WEIGHT, 3'd0, 4'd0, 4'd0, 16'h0000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_WEIGHT, 3'd0, 4'd0, 4'd0, 16'h8000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_ACT, 3'd0, 4'd0, 4'd0, 16'h8000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_LOAD_ERR, 3'd0, 4'd0, 4'd0, 16'h8000, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_RUN_UPDATE, 3'd7, 4'd15, 4'd15, 16'hffff, 0, bpwu_pkg::KIND_DONE, 0, 0},
      '{bpwu_pkg::OP_READ_WEIGHT, 3'd0, 4'd0, 4'd0, 16'h0000, 0, bpwu_pkg::KIND_DONE, 0, 0}
   };

   initial begin
      req.valid = 1'b0;
      req.operation = '0;
      req.layer_sel = '0;
      req.row_sel = '0;
      req.col_sel = '0;
      req.value_in = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest network for the hand-written part
      csr_write(bpwu_pkg::CSR_LAYER_COUNT, 16'd2);
      csr_write(bpwu_pkg::CSR_WIDTH_BASE, 16'd1);
      csr_write(4'(bpwu_pkg::CSR_WIDTH_BASE + 1), 16'd1);
      drain();
      foreach (script[n])
         send(script[n].op, script[n].lay, script[n].row, script[n].col, script[n].val,
              script[n].typed, script[n].kind, script[n].value, script[n].sat);
      drain();

      // long result stall while reads keep coming
      hold_req = 1'b1;
      repeat (40) send(bpwu_pkg::OP_READ_WEIGHT, 3'd0, 4'd0, 4'd0, any16());
      drain();

      while (nitems < 700) begin
         configure();
         fill_and_run();
         drain();
      end

      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("mlp_backprop_weight_update: match");
      end else begin
         $display("mlp_backprop_weight_update: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("mlp_backprop_weight_update: mismatch");
      $finish;
   end

endmodule
